// File: sv/sebp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the serial EEPROM bit protocol block.
// Used by sebp_ctrl, sebp_datapath and serial_eeprom_bit_protocol.
package sebp_pkg;

  // Default store sizes in bytes.
  localparam int unsigned LARGE_BYTES_DEF = 8192;
  localparam int unsigned SMALL_BYTES_DEF = 512;

  // Configuration register map.
  localparam int unsigned REG_IDX_W  = 1;
  localparam int unsigned PADDR_W    = REG_IDX_W + 2;
  localparam logic [REG_IDX_W-1:0] REG_START_LARGE = 1'b0;

  // Bus command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Protocol thresholds on the remaining transfer count.
  localparam logic [15:0] GROW_LIMIT  = 16'd72;
  localparam logic [15:0] WADDR_LIMIT = 16'd65;
  localparam logic [15:0] STOP_COUNT  = 16'd1;

  // Read slot counts: dummy slots first, then data slots.
  localparam logic [6:0] READ_SLOTS = 7'd68;
  localparam logic [6:0] DATA_SLOTS = 7'd64;

  // Read result codes and the erased byte value.
  localparam logic [7:0] READY_VALUE = 8'd1;
  localparam logic [7:0] DUMMY_VALUE = 8'd0;
  localparam logic [7:0] RANGE_ERR   = 8'hFF;
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  // Serial protocol phase.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PENDING,
    PH_WRITE,
    PH_READ_ADDR,
    PH_READ
  } phase_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_READY,
    ST_FETCH
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic sweep_en;
    logic item_accept;
    logic fetch_done;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;
    logic need_fetch;
    logic out_busy;
    logic cfg_clear;
  } dp_status_t;

endpackage

// File: sv/sebp_store.sv
`timescale 1ns / 1ps
// Byte store with a bit-masked write port and a registered read port.
// Depends on nothing else in the project.
module sebp_store #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wmask_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // Write only the bits selected by the mask.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < 8; b++) begin
        if (wmask_i[b]) begin
          mem_q[waddr_i][b] <= wdata_i[b];
        end
      end
    end
  end

  // Registered read.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/sebp_ctrl.sv
`timescale 1ns / 1ps
// Controller: clearing pass, request acceptance and memory fetch sequencing.
// Depends on sebp_pkg for the state enum and the command and status structs.
module sebp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   out_ready_i,
  input  sebp_pkg::dp_status_t   status_i,
  output logic                   in_ready_o,
  output sebp_pkg::ctrl_cmd_t    cmd_o
);

  sebp_pkg::ctrl_state_e state_q, state_d;
  logic in_ready;

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sebp_pkg::ST_SWEEP;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    in_ready = (state_q == sebp_pkg::ST_READY) && (!status_i.out_busy || out_ready_i);
    cmd_o.sweep_en    = (state_q == sebp_pkg::ST_SWEEP);
    cmd_o.item_accept = in_valid_i && in_ready;
    cmd_o.fetch_done  = (state_q == sebp_pkg::ST_FETCH);
    state_d = state_q;
    if (status_i.cfg_clear) begin
      state_d = sebp_pkg::ST_SWEEP;
    end else begin
      unique case (state_q)
        sebp_pkg::ST_SWEEP: begin
          if (status_i.sweep_last) state_d = sebp_pkg::ST_READY;
        end
        sebp_pkg::ST_READY: begin
          if (cmd_o.item_accept && status_i.need_fetch) state_d = sebp_pkg::ST_FETCH;
        end
        sebp_pkg::ST_FETCH: begin
          state_d = sebp_pkg::ST_READY;
        end
        default: begin
          state_d = sebp_pkg::ST_READY;
        end
      endcase
    end
  end

  assign in_ready_o = in_ready;

endmodule

// File: sv/sebp_datapath.sv
`timescale 1ns / 1ps
// Datapath: protocol registers, bit addresses, store access and result register.
// Depends on sebp_pkg and instantiates sebp_store.
module sebp_datapath #(
  parameter int unsigned LARGE_BYTES = sebp_pkg::LARGE_BYTES_DEF,
  parameter int unsigned SMALL_BYTES = sebp_pkg::SMALL_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sebp_pkg::ctrl_cmd_t           cmd_i,
  output sebp_pkg::dp_status_t          status_o,
  input  logic                          bus_cmd_i,
  input  logic                          bit_value_i,
  input  logic [15:0]                   transfer_remaining_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [7:0]                    read_value_o,
  input  logic                          cfg_wr_i,
  input  logic [sebp_pkg::PADDR_W-1:0]  cfg_addr_i,
  input  logic [31:0]                   cfg_wdata_i,
  output logic [31:0]                   cfg_rdata_o
);

  localparam int unsigned AW = (LARGE_BYTES > 1) ? $clog2(LARGE_BYTES) : 1;
  localparam int unsigned SMALL_EFF = (SMALL_BYTES < LARGE_BYTES) ? SMALL_BYTES : LARGE_BYTES;
  localparam logic [31:0] LARGE_SIZE = 32'(LARGE_BYTES);
  localparam logic [31:0] SMALL_SIZE = 32'(SMALL_EFF);
  localparam logic [AW-1:0] SMALL_PTR = AW'(SMALL_EFF);
  localparam logic [AW-1:0] LAST_PTR = AW'(LARGE_BYTES - 1);
  localparam logic HAS_UPPER = (SMALL_EFF < LARGE_BYTES);

  sebp_pkg::phase_e phase_q, phase_d;
  logic            mode_large_q, mode_large_d;
  logic            start_large_q, start_large_d;
  logic [31:0]     wr_addr_q, wr_addr_d;
  logic [31:0]     rd_addr_q, rd_addr_d;
  logic [6:0]      bits_left_q, bits_left_d;
  logic [AW-1:0]   sweep_ptr_q, sweep_ptr_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      read_value_q, read_value_d;
  logic [2:0]      sel_q;

  logic            cfg_hit, cfg_clear;
  logic [31:0]     store_size;
  logic [31:0]     wr_byte, rd_byte, rd_bit_addr;
  logic            wr_in_range, rd_in_range;
  logic            is_write, in_read_phase, slot_data, need_fetch;
  logic [6:0]      bl_next;
  logic [5:0]      step;
  logic [7:0]      imm_value;
  logic            load_now;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [7:0]      mem_wmask, mem_wdata, mem_rdata;

  // Configuration decode; writing small mode schedules a clear of the upper bytes.
  assign cfg_hit   = cfg_wr_i && (cfg_addr_i[sebp_pkg::PADDR_W-1:2] == sebp_pkg::REG_START_LARGE);
  assign cfg_clear = cfg_hit && !cfg_wdata_i[0] && HAS_UPPER;
  assign cfg_rdata_o = (cfg_addr_i[sebp_pkg::PADDR_W-1:2] == sebp_pkg::REG_START_LARGE)
                     ? {31'b0, start_large_q} : 32'b0;

  // Address and slot arithmetic for the current request.
  always_comb begin
    store_size    = mode_large_q ? LARGE_SIZE : SMALL_SIZE;
    wr_byte       = {3'b0, wr_addr_q[31:3]};
    wr_in_range   = wr_byte < store_size;
    is_write      = (bus_cmd_i == sebp_pkg::CMD_WRITE);
    in_read_phase = (phase_q == sebp_pkg::PH_READ);
    bl_next       = bits_left_q - 7'd1;
    slot_data     = bl_next < sebp_pkg::DATA_SLOTS;
    step          = 6'd63 - bl_next[5:0];
    rd_bit_addr   = rd_addr_q + {26'b0, step};
    rd_byte       = {3'b0, rd_bit_addr[31:3]};
    rd_in_range   = rd_byte < store_size;
    need_fetch    = !is_write && in_read_phase && slot_data && rd_in_range;
    if (!in_read_phase) begin
      imm_value = sebp_pkg::READY_VALUE;
    end else if (!slot_data) begin
      imm_value = sebp_pkg::DUMMY_VALUE;
    end else begin
      imm_value = sebp_pkg::RANGE_ERR;
    end
  end

  // Protocol state update.
  always_comb begin
    phase_d       = phase_q;
    mode_large_d  = mode_large_q;
    start_large_d = start_large_q;
    wr_addr_d     = wr_addr_q;
    rd_addr_d     = rd_addr_q;
    bits_left_d   = bits_left_q;
    if (cfg_hit) begin
      start_large_d = cfg_wdata_i[0];
      mode_large_d  = cfg_wdata_i[0];
      phase_d       = sebp_pkg::PH_IDLE;
      wr_addr_d     = 32'd0;
      rd_addr_d     = 32'd0;
      bits_left_d   = 7'd0;
    end else if (cmd_i.item_accept) begin
      if (is_write) begin
        unique case (phase_q)
          sebp_pkg::PH_PENDING: begin
            if (bit_value_i) begin
              phase_d   = sebp_pkg::PH_READ_ADDR;
              rd_addr_d = 32'd0;
            end else begin
              phase_d   = sebp_pkg::PH_WRITE;
              wr_addr_d = 32'd0;
            end
          end
          sebp_pkg::PH_WRITE: begin
            if (transfer_remaining_i > sebp_pkg::WADDR_LIMIT) begin
              if (transfer_remaining_i > sebp_pkg::GROW_LIMIT) mode_large_d = 1'b1;
              wr_addr_d = {wr_addr_q[30:0], 1'b0} | {25'b0, bit_value_i, 6'b0};
            end else if (transfer_remaining_i == sebp_pkg::STOP_COUNT) begin
              phase_d = sebp_pkg::PH_IDLE;
            end else if (wr_in_range) begin
              wr_addr_d = wr_addr_q + 32'd1;
            end
          end
          sebp_pkg::PH_READ_ADDR: begin
            if (transfer_remaining_i > sebp_pkg::STOP_COUNT) begin
              if (transfer_remaining_i > sebp_pkg::GROW_LIMIT) mode_large_d = 1'b1;
              rd_addr_d = {rd_addr_q[30:0], 1'b0} | {25'b0, bit_value_i, 6'b0};
            end else begin
              bits_left_d = sebp_pkg::READ_SLOTS;
              phase_d     = sebp_pkg::PH_READ;
            end
          end
          default: begin
            phase_d = bit_value_i ? sebp_pkg::PH_PENDING : sebp_pkg::PH_IDLE;
          end
        endcase
      end else if (in_read_phase) begin
        bits_left_d = bl_next;
        if (bl_next == 7'd0) phase_d = sebp_pkg::PH_IDLE;
      end
    end
  end

  // Clearing pass pointer; a pass already under way keeps its lower start.
  always_comb begin
    sweep_ptr_d = sweep_ptr_q;
    if (cfg_clear) begin
      sweep_ptr_d = (cmd_i.sweep_en && (sweep_ptr_q < SMALL_PTR)) ? sweep_ptr_q : SMALL_PTR;
    end else if (cmd_i.sweep_en) begin
      sweep_ptr_d = sweep_ptr_q + AW'(1);
    end
  end

  // Store write port: clearing pass or one serial data bit.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr_q[3 +: AW];
    mem_wmask = 8'h80 >> wr_addr_q[2:0];
    mem_wdata = {8{bit_value_i}};
    if (cmd_i.sweep_en) begin
      mem_we    = 1'b1;
      mem_waddr = sweep_ptr_q;
      mem_wmask = 8'hFF;
      mem_wdata = sebp_pkg::ERASED_BYTE;
    end else if (cmd_i.item_accept && is_write && (phase_q == sebp_pkg::PH_WRITE) &&
                 (transfer_remaining_i <= sebp_pkg::WADDR_LIMIT) &&
                 (transfer_remaining_i != sebp_pkg::STOP_COUNT) && wr_in_range) begin
      mem_we = 1'b1;
    end
  end

  assign mem_raddr = rd_bit_addr[3 +: AW];

  sebp_store #(
    .DEPTH (LARGE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wmask_i (mem_wmask),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Result register: immediate answers load at acceptance, data bits after the fetch.
  always_comb begin
    load_now     = cmd_i.item_accept && !is_write && !need_fetch;
    read_value_d = cmd_i.fetch_done ? {7'b0, mem_rdata[3'd7 - sel_q]} : imm_value;
    if (load_now || cmd_i.fetch_done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and protocol registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= sebp_pkg::PH_IDLE;
      mode_large_q  <= 1'b0;
      start_large_q <= 1'b0;
      wr_addr_q     <= 32'd0;
      rd_addr_q     <= 32'd0;
      bits_left_q   <= 7'd0;
      sweep_ptr_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      phase_q       <= phase_d;
      mode_large_q  <= mode_large_d;
      start_large_q <= start_large_d;
      wr_addr_q     <= wr_addr_d;
      rd_addr_q     <= rd_addr_d;
      bits_left_q   <= bits_left_d;
      sweep_ptr_q   <= sweep_ptr_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (load_now || cmd_i.fetch_done) read_value_q <= read_value_d;
    if (cmd_i.item_accept) sel_q <= step[2:0];
  end

  assign status_o.sweep_last = (sweep_ptr_q == LAST_PTR);
  assign status_o.need_fetch = need_fetch;
  assign status_o.out_busy   = out_valid_q;
  assign status_o.cfg_clear  = cfg_clear;

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;

endmodule

// File: sv/serial_eeprom_bit_protocol.sv
`timescale 1ns / 1ps
// Serial EEPROM bit protocol engine: bus write and bus read requests over a byte store.
// Depends on sebp_pkg, sebp_ctrl and sebp_datapath.
//
// Usage:
//   The input channel (in_valid_i/in_ready_o) carries one bus access per request:
//   cmd_i 0 writes the serial bit bit_value_i, cmd_i 1 reads one bit. Only reads
//   produce a result on the output channel (out_valid_o/out_ready_i), read_value_o.
//   A write request completes in the cycle it is accepted. A read answers in the
//   cycle after acceptance when the answer is ready, a dummy slot or out of range;
//   a stored data bit passes the registered store read and then the result register.
//   Sustained rate: one request per cycle while the result register is free or being
//   taken; none is taken while a stored data bit is fetched. The result register
//   lets the next request in while the receiver takes the previous result; a stalled
//   receiver holds read_value_o and blocks further requests only until it takes it.
//   After reset a clearing pass writes 0xFF to all LARGE_BYTES bytes, one byte per
//   cycle, with in_ready_o low. Writing start_large as 0 runs a pass over the
//   bytes from the small size up. The APB port is taken during a pass as always.
module serial_eeprom_bit_protocol #(
  parameter int unsigned LARGE_BYTES = sebp_pkg::LARGE_BYTES_DEF,
  parameter int unsigned SMALL_BYTES = sebp_pkg::SMALL_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic                          bit_value_i,
  input  logic [15:0]                   transfer_remaining_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    read_value_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sebp_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  sebp_pkg::ctrl_cmd_t  ctrl_cmd;
  sebp_pkg::dp_status_t dp_status;
  logic                 cfg_wr;

  // Writes complete in the access phase; no wait states.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  sebp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .status_i    (dp_status),
    .in_ready_o  (in_ready_o),
    .cmd_o       (ctrl_cmd)
  );

  sebp_datapath #(
    .LARGE_BYTES (LARGE_BYTES),
    .SMALL_BYTES (SMALL_BYTES)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (ctrl_cmd),
    .status_o             (dp_status),
    .bus_cmd_i            (cmd_i),
    .bit_value_i          (bit_value_i),
    .transfer_remaining_i (transfer_remaining_i),
    .out_ready_i          (out_ready_i),
    .out_valid_o          (out_valid_o),
    .read_value_o         (read_value_o),
    .cfg_wr_i             (cfg_wr),
    .cfg_addr_i           (paddr),
    .cfg_wdata_i          (pwdata),
    .cfg_rdata_o          (prdata)
  );

  // No request is taken while the clearing pass runs.
  a_no_accept_in_sweep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.sweep_en |-> !in_ready_o)
    else $error("request accepted during clearing pass");

  // A store fetch only follows an accepted read request.
  a_fetch_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.fetch_done |-> $past(in_valid_i && in_ready_o && (cmd_i == sebp_pkg::CMD_READ)))
    else $error("fetch without a read request");

  // The result register is free when a fetched bit arrives.
  a_fetch_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.fetch_done |-> !out_valid_o)
    else $error("fetched bit would overwrite a pending result");

  // A write request never produces a result.
  a_write_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (cmd_i == sebp_pkg::CMD_WRITE) && !out_valid_o)
      |=> !out_valid_o)
    else $error("result produced by a write request");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for serial_eeprom_bit_protocol: serial write and read
// transfers, idle bus accesses and size changes, checked against a shadow model.
// Depends on sebp_pkg and the serial_eeprom_bit_protocol RTL.
module testbench;

  localparam int unsigned LARGE_BYTES = sebp_pkg::LARGE_BYTES_DEF;
  localparam int unsigned SMALL_BYTES = sebp_pkg::SMALL_BYTES_DEF;
  localparam int unsigned SMALL_EFF = (SMALL_BYTES < LARGE_BYTES) ? SMALL_BYTES : LARGE_BYTES;
  localparam int IDLE_LIMIT = 50000;
  localparam int DRAIN_CYCLES = 16;
  localparam int CFG_SETTLE = 6;
  localparam int RANDOM_ACCESSES = 60;
  localparam int HOLD_OFF_CYCLES = 400;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_MOSTLY,
    RX_PERIODIC,
    RX_SPARSE
  } rx_style_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic cmd_i = sebp_pkg::CMD_READ;
  logic bit_value_i = 1'b0;
  logic [15:0] transfer_remaining_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] read_value_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [sebp_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Shadow copy of the device state.
  logic [7:0] shadow_store [LARGE_BYTES];
  logic shadow_mode_large;
  sebp_pkg::phase_e shadow_phase;
  logic [31:0] shadow_wr_addr;
  logic [31:0] shadow_rd_addr;
  logic [6:0] shadow_slots_left;

  logic [7:0] expected_reads [$];
  int failures = 0;
  int accesses_sent = 0;
  int burst_left = 0;
  logic sender_steady = 1'b0;
  int idle_cycles = 0;
  int hold_off_request = 0;
  int hold_left = 0;
  int ready_cycle = 0;
  rx_style_e ready_style = RX_ALWAYS;
  logic [31:0] last_word = '0;
  int last_naddr = 6;
  logic [7:0] got_value;

  serial_eeprom_bit_protocol #(
    .LARGE_BYTES(LARGE_BYTES),
    .SMALL_BYTES(SMALL_BYTES)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .cmd_i(cmd_i),
    .bit_value_i(bit_value_i),
    .transfer_remaining_i(transfer_remaining_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .read_value_o(read_value_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Current store size in bytes.
  function automatic int unsigned store_bytes();
    return shadow_mode_large ? LARGE_BYTES : SMALL_EFF;
  endfunction

  function automatic void clear_protocol();
    shadow_phase = sebp_pkg::PH_IDLE;
    shadow_wr_addr = '0;
    shadow_rd_addr = '0;
    shadow_slots_left = '0;
  endfunction

  // Setting the size behaves like a power-on; shrinking erases the upper bytes.
  function automatic void apply_start_large(logic large_mode);
    shadow_mode_large = large_mode;
    if (!large_mode) begin
      for (int unsigned i = SMALL_EFF; i < LARGE_BYTES; i++) begin
        shadow_store[i] = sebp_pkg::ERASED_BYTE;
      end
    end
    clear_protocol();
  endfunction

  // Serial bit written on the bus: advances the protocol.
  function automatic void apply_bus_write(logic serial_bit, logic [15:0] rem);
    logic [31:0] byte_idx;
    logic [2:0] bit_pos;
    case (shadow_phase)
      sebp_pkg::PH_PENDING: begin
        if (serial_bit) begin
          shadow_phase = sebp_pkg::PH_READ_ADDR;
          shadow_rd_addr = '0;
        end else begin
          shadow_phase = sebp_pkg::PH_WRITE;
          shadow_wr_addr = '0;
        end
      end
      sebp_pkg::PH_WRITE: begin
        if (rem > sebp_pkg::WADDR_LIMIT) begin
          if (rem > sebp_pkg::GROW_LIMIT) shadow_mode_large = 1'b1;
          shadow_wr_addr = (shadow_wr_addr << 1) | {25'd0, serial_bit, 6'd0};
        end else if (rem == sebp_pkg::STOP_COUNT) begin
          shadow_phase = sebp_pkg::PH_IDLE;
        end else begin
          // Data bits land only inside the store; otherwise the address holds.
          byte_idx = shadow_wr_addr >> 3;
          if (byte_idx < store_bytes()) begin
            bit_pos = 3'd7 - shadow_wr_addr[2:0];
            shadow_store[byte_idx][bit_pos] = serial_bit;
            shadow_wr_addr = shadow_wr_addr + 32'd1;
          end
        end
      end
      sebp_pkg::PH_READ_ADDR: begin
        if (rem > sebp_pkg::STOP_COUNT) begin
          if (rem > sebp_pkg::GROW_LIMIT) shadow_mode_large = 1'b1;
          shadow_rd_addr = (shadow_rd_addr << 1) | {25'd0, serial_bit, 6'd0};
        end else begin
          shadow_slots_left = sebp_pkg::READ_SLOTS;
          shadow_phase = sebp_pkg::PH_READ;
        end
      end
      default: shadow_phase = serial_bit ? sebp_pkg::PH_PENDING : sebp_pkg::PH_IDLE;
    endcase
  endfunction

  // Bus read: ready outside read mode, then dummy slots, then data bits.
  function automatic logic [7:0] predict_bus_read();
    logic [31:0] slot;
    logic [31:0] byte_idx;
    logic [7:0] value;
    if (shadow_phase != sebp_pkg::PH_READ) return sebp_pkg::READY_VALUE;
    shadow_slots_left = shadow_slots_left - 7'd1;
    if (shadow_slots_left >= sebp_pkg::DATA_SLOTS) return sebp_pkg::DUMMY_VALUE;
    slot = sebp_pkg::DATA_SLOTS - 7'd1 - shadow_slots_left;
    byte_idx = (shadow_rd_addr + slot) >> 3;
    if (byte_idx < store_bytes()) value = {7'd0, shadow_store[byte_idx][3'd7 - slot[2:0]]};
    else value = sebp_pkg::RANGE_ERR;
    if (shadow_slots_left == 7'd0) shadow_phase = sebp_pkg::PH_IDLE;
    return value;
  endfunction

  // Sends one request and updates the shadow model when it is taken.
  task automatic send_access(logic cmd, logic serial_bit, logic [15:0] rem);
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    bit_value_i <= serial_bit;
    transfer_remaining_i <= rem;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (cmd == sebp_pkg::CMD_READ) expected_reads.push_back(predict_bus_read());
    else apply_bus_write(serial_bit, rem);
    accesses_sent++;
    if (accesses_sent % 160 == 0) sender_steady = ($urandom_range(0, 2) == 0);
    // Bursts of random length separated by short gaps.
    if (!sender_steady) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic sender_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Writes the size register once the block has drained.
  task automatic write_start_large(logic large_mode);
    sender_idle();
    while (expected_reads.size() != 0) @(posedge clk_i);
    repeat (CFG_SETTLE) @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sebp_pkg::REG_START_LARGE, 2'b00};
    pwdata <= {31'($urandom), large_mode};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    apply_start_large(large_mode);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Write transfer: header 1,0, address bits, data bits, stop bit.
  task automatic write_transfer(int naddr, logic [31:0] word, int ndata, logic odd_counts,
                                logic [63:0] pattern);
    logic [15:0] rem;
    send_access(sebp_pkg::CMD_WRITE, 1'b1, 16'($urandom));
    send_access(sebp_pkg::CMD_WRITE, 1'b0, 16'($urandom));
    for (int i = 0; i < naddr; i++) begin
      send_access(sebp_pkg::CMD_WRITE, word[naddr-1-i],
                  16'(sebp_pkg::WADDR_LIMIT + naddr - i));
    end
    for (int j = 0; j < ndata; j++) begin
      rem = (ndata - j + 1 > sebp_pkg::WADDR_LIMIT) ? sebp_pkg::WADDR_LIMIT
                                                    : 16'(ndata - j + 1);
      if (odd_counts && $urandom_range(0, 3) == 0) begin
        rem = ($urandom_range(0, 1) == 0) ? 16'd0
                                          : 16'($urandom_range(2, sebp_pkg::WADDR_LIMIT));
      end
      send_access(sebp_pkg::CMD_WRITE, pattern[63 - (j % 64)], rem);
    end
    send_access(sebp_pkg::CMD_WRITE, 1'($urandom_range(0, 1)), sebp_pkg::STOP_COUNT);
    last_word = word;
    last_naddr = naddr;
  endtask

  // Read transfer: header 1,1, address bits, stop bit, then bus reads.
  task automatic read_transfer(int naddr, logic [31:0] word, int nreads, logic grow,
                               logic [15:0] stop_rem);
    send_access(sebp_pkg::CMD_WRITE, 1'b1, 16'($urandom));
    send_access(sebp_pkg::CMD_WRITE, 1'b1, 16'($urandom));
    for (int i = 0; i < naddr; i++) begin
      send_access(sebp_pkg::CMD_WRITE, word[naddr-1-i], 16'(naddr - i + 1 + (grow ? 72 : 0)));
    end
    send_access(sebp_pkg::CMD_WRITE, 1'($urandom_range(0, 1)), stop_rem);
    repeat (nreads) send_access(sebp_pkg::CMD_READ, 1'($urandom_range(0, 1)), 16'($urandom));
  endtask

  // Steers the protocol back to idle so the next transfer is well formed.
  task automatic return_to_idle();
    while (shadow_phase != sebp_pkg::PH_IDLE) begin
      case (shadow_phase)
        sebp_pkg::PH_PENDING, sebp_pkg::PH_READ:
          send_access(sebp_pkg::CMD_WRITE, 1'b0, 16'($urandom));
        default: send_access(sebp_pkg::CMD_WRITE, 1'b0, sebp_pkg::STOP_COUNT);
      endcase
    end
  endtask

  // Requests with arbitrary fields, counts near the thresholds included.
  task automatic noise_accesses(int count);
    logic [15:0] rem;
    repeat (count) begin
      case ($urandom_range(0, 7))
        0: rem = 16'd0;
        1: rem = sebp_pkg::STOP_COUNT;
        2: rem = sebp_pkg::WADDR_LIMIT;
        3: rem = sebp_pkg::GROW_LIMIT + 16'd1;
        4: rem = 16'hFFFF;
        default: rem = 16'($urandom);
      endcase
      send_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), rem);
    end
  endtask

  // Reads and writes on an idle bus, an empty write and an abandoned read.
  task automatic test_idle_bus();
    send_access(sebp_pkg::CMD_READ, 1'b1, 16'hFFFF);
    send_access(sebp_pkg::CMD_WRITE, 1'b0, 16'h0000);
    send_access(sebp_pkg::CMD_WRITE, 1'b0, 16'hFFFF);
    send_access(sebp_pkg::CMD_READ, 1'b0, 16'h0000);
    send_access(sebp_pkg::CMD_WRITE, 1'b1, 16'h1234);
    send_access(sebp_pkg::CMD_READ, 1'b1, 16'hAAAA);
    send_access(sebp_pkg::CMD_WRITE, 1'b0, 16'h5555);
    send_access(sebp_pkg::CMD_WRITE, 1'b1, sebp_pkg::STOP_COUNT);
    send_access(sebp_pkg::CMD_WRITE, 1'b1, 16'hFFFF);
    send_access(sebp_pkg::CMD_WRITE, 1'b1, 16'h0000);
    send_access(sebp_pkg::CMD_WRITE, 1'b0, sebp_pkg::STOP_COUNT);
    repeat (6) send_access(sebp_pkg::CMD_READ, 1'b0, 16'($urandom));
    send_access(sebp_pkg::CMD_WRITE, 1'b0, 16'h00FF);
    send_access(sebp_pkg::CMD_READ, 1'b1, 16'hFF00);
  endtask

  // Writes to the first and last word of the small store, read back.
  task automatic test_write_then_read();
    write_transfer(6, 32'd0, 8, 1'b0, 64'd0);
    read_transfer(6, 32'd0, 68, 1'b0, sebp_pkg::STOP_COUNT);
    write_transfer(6, 32'd63, 8, 1'b0, {$urandom, $urandom});
    read_transfer(6, 32'd63, 12, 1'b0, 16'd0);
  endtask

  // Protocol corners: odd counts, abandoned reads, range limits, address wrap.
  task automatic test_transfer_corners();
    logic [31:0] word;
    logic [31:0] other;
    word = $urandom_range(0, 62);
    other = $urandom_range(0, 63);
    // Extra data bits and zero counts inside the data part.
    write_transfer(6, word, 72, 1'b1, {$urandom, $urandom});
    read_transfer(6, word + 1, 12, 1'b0, sebp_pkg::STOP_COUNT);
    // A write arriving during read slots abandons the read.
    read_transfer(6, word, 8, 1'b0, sebp_pkg::STOP_COUNT);
    write_transfer(6, other, 8, 1'b0, {$urandom, $urandom});
    read_transfer(6, other, 12, 1'b0, 16'd0);
    // Addresses past the small store.
    write_transfer(7, 32'd70, 8, 1'b0, {$urandom, $urandom});
    read_transfer(7, 32'd70, 12, 1'b0, sebp_pkg::STOP_COUNT);
    read_transfer(6, 32'd6, 12, 1'b0, sebp_pkg::STOP_COUNT);
    // Bit addresses that overflow 32 bits.
    read_transfer(32, 32'hFFFF_FFFF, 12, 1'b0, sebp_pkg::STOP_COUNT);
    write_transfer(32, 32'hFC00_0001, 8, 1'b0, {$urandom, $urandom});
    read_transfer(6, 32'd1, 12, 1'b0, sebp_pkg::STOP_COUNT);
  endtask

  // Both sizes, shrinking erases the upper part, growth on long counts.
  task automatic test_size_modes();
    write_start_large(1'b1);
    write_transfer(14, 32'h3FFF, 8, 1'b0, {$urandom, $urandom});
    read_transfer(14, 32'h3FFF, 12, 1'b0, sebp_pkg::STOP_COUNT);
    write_start_large(1'b0);
    read_transfer(14, 32'h3FFF, 12, 1'b0, sebp_pkg::STOP_COUNT);
    read_transfer(14, 32'h3FFF, 12, 1'b1, sebp_pkg::STOP_COUNT);
    write_start_large(1'b0);
    write_transfer(14, 32'h2000, 8, 1'b0, {$urandom, $urandom});
    write_start_large(1'b0);
    write_transfer(14, 32'h2000, 8, 1'b0, {$urandom, $urandom});
    read_transfer(14, 32'h2000, 12, 1'b0, sebp_pkg::STOP_COUNT);
    write_start_large(1'b0);
  endtask

  // The receiver holds off for a long stretch while reads keep coming.
  task automatic test_receiver_hold_off();
    logic saved_steady;
    saved_steady = sender_steady;
    sender_steady = 1'b1;
    hold_off_request = HOLD_OFF_CYCLES;
    read_transfer(6, 32'($urandom_range(0, 63)), 12, 1'b0, sebp_pkg::STOP_COUNT);
    write_transfer(6, 32'($urandom_range(0, 63)), 8, 1'b0, {$urandom, $urandom});
    sender_steady = saved_steady;
  endtask

  // Mostly well-formed transfers with random content, some noise and resizes.
  task automatic test_random_traffic();
    int target;
    int choice;
    int naddr;
    int nreads;
    logic [31:0] word;
    target = accesses_sent + RANDOM_ACCESSES;
    while (accesses_sent < target) begin
      choice = $urandom_range(0, 99);
      if (choice < 85) return_to_idle();
      naddr = shadow_mode_large ? 14 : 6;
      if ($urandom_range(0, 6) == 0) naddr = $urandom_range(0, 32);
      word = {$urandom};
      if (choice < 40) begin
        write_transfer(naddr, word, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 80) : 16,
                       $urandom_range(0, 4) == 0, {$urandom, $urandom});
      end else if (choice < 78) begin
        if ($urandom_range(0, 4) < 3) begin
          naddr = last_naddr;
          word = last_word;
        end
        nreads = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 80) : 20;
        read_transfer(naddr, word, nreads, $urandom_range(0, 9) == 0,
                      16'($urandom_range(0, 1)));
      end else if (choice < 95) begin
        noise_accesses($urandom_range(1, 8));
      end else begin
        write_start_large(1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Receiver: rotating stall patterns plus an occasional long hold-off.
  always @(posedge clk_i) begin
    ready_cycle++;
    if (ready_cycle % 700 == 0) ready_style = rx_style_e'($urandom_range(0, 3));
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (hold_off_request > 0) begin
      hold_left = hold_off_request - 1;
      hold_off_request = 0;
      out_ready_i <= 1'b0;
    end else begin
      case (ready_style)
        RX_ALWAYS: out_ready_i <= 1'b1;
        RX_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_ready_i <= (ready_cycle % 3 != 0);
        default: out_ready_i <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Each accepted result is compared with the oldest predicted read.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (expected_reads.size() == 0) begin
        $error("read_value expected none actual %0d", read_value_o);
        failures++;
      end else begin
        got_value = expected_reads.pop_front();
        if (read_value_o !== got_value) begin
          $error("read_value expected %0d actual %0d", got_value, read_value_o);
          failures++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted request, result or register write.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o === 1'b1) || (out_valid_o === 1'b1 && out_ready_i) ||
        (psel && penable && pready === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int unsigned i = 0; i < LARGE_BYTES; i++) shadow_store[i] = sebp_pkg::ERASED_BYTE;
    shadow_mode_large = 1'b0;
    clear_protocol();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_bus();
    test_write_then_read();
    test_transfer_corners();
    test_size_modes();
    test_receiver_hold_off();
    test_random_traffic();
    sender_idle();
    while (expected_reads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
